FILE: rtl/core/rucs_pkg.sv
`default_nettype none
package rucs_pkg;

   // Q16.16 constants and the infinity codes.
   localparam logic signed [33:0] Q_ONE   = 34'sd65536;
   localparam logic signed [31:0] T_POS_INF = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] T_NEG_INF = 32'sh8000_0000;

   // Reset value of the parallel threshold.
   localparam logic [16:0] THRESH_RESET = 17'd7;

   // Quotient bits produced by the divider, one per stage.
   localparam int QUO_BITS = 33;

   // Register stages from an accepted input beat to the result beat.
   localparam int LATENCY = QUO_BITS + 4;

   // Number of axes handled side by side.
   localparam int AXES = 3;

   // State carried down one divider lane.
   typedef struct packed {
      logic [49:0] rem;
      logic [32:0] quo;
      logic [31:0] dmag;
      logic        neg;
      logic        ovf;
      logic        par;
      logic        npos;
      logic        nneg;
   } div_stage_type;

endpackage
`default_nettype wire

FILE: rtl/core/rucs_slab_lane.sv
`default_nettype none
module rucs_slab_lane (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic               exit_side,
   input  wire logic [16:0]        thresh,
   input  wire logic signed [31:0] origin,
   input  wire logic signed [31:0] dir,
   output logic signed [31:0]      t_out
);

   rucs_pkg::div_stage_type st_ff [0:rucs_pkg::QUO_BITS];
   rucs_pkg::div_stage_type st_in [0:rucs_pkg::QUO_BITS];
   logic signed [31:0]      res_ff;
   logic signed [31:0]      res_in;

   logic signed [33:0] num;
   logic [32:0]        nmag;

   // Setup: numerator, magnitudes, parallel test and the overflow check.
   always_comb begin
      num = exit_side ? (rucs_pkg::Q_ONE - 34'(origin)) : (-rucs_pkg::Q_ONE - 34'(origin));
      nmag = num[33] ? 33'(-num) : num[32:0];
      st_in[0].rem  = {1'b0, nmag, 16'b0};
      st_in[0].quo  = '0;
      st_in[0].dmag = dir[31] ? 32'(-dir) : 32'(dir);
      st_in[0].neg  = num[33] ^ dir[31];
      st_in[0].ovf  = {15'b0, st_in[0].rem} >= {st_in[0].dmag, 33'b0};
      st_in[0].par  = (dir == '0) || (st_in[0].dmag < {15'b0, thresh});
      st_in[0].npos = !num[33] && (num != '0);
      st_in[0].nneg = num[33];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0] <= st_in[0];
      end
   end

   // One quotient bit per stage, most significant first.
   for (genvar i = 0; i < rucs_pkg::QUO_BITS; i++) begin : g_step
      localparam int B = rucs_pkg::QUO_BITS - 1 - i;
      logic [64:0] trial;
      always_comb begin
         trial = 65'(st_ff[i].dmag) << B;
         st_in[i + 1] = st_ff[i];
         if ({15'b0, st_ff[i].rem} >= trial) begin
            st_in[i + 1].rem    = st_ff[i].rem - trial[49:0];
            st_in[i + 1].quo[B] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[i + 1] <= st_in[i + 1];
         end
      end
   end

   // Sign, saturation and the parallel cases.
   always_comb begin
      rucs_pkg::div_stage_type f;
      f = st_ff[rucs_pkg::QUO_BITS];
      if (f.par) begin
         if (f.npos) begin
            res_in = rucs_pkg::T_POS_INF;
         end else if (f.nneg) begin
            res_in = rucs_pkg::T_NEG_INF;
         end else begin
            res_in = exit_side ? rucs_pkg::T_POS_INF : rucs_pkg::T_NEG_INF;
         end
      end else if (f.neg) begin
         if (f.ovf || f.quo > 33'h0_8000_0000) begin
            res_in = rucs_pkg::T_NEG_INF;
         end else begin
            res_in = 32'(-f.quo);
         end
      end else begin
         if (f.ovf || f.quo[32:31] != 2'b00) begin
            res_in = rucs_pkg::T_POS_INF;
         end else begin
            res_in = f.quo[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign t_out = res_ff;

endmodule
`default_nettype wire

FILE: rtl/core/rucs_merge.sv
`default_nettype none
module rucs_merge (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic signed [31:0] t_entry [rucs_pkg::AXES],
   input  wire logic signed [31:0] t_exit  [rucs_pkg::AXES],
   output logic                    hit,
   output logic signed [31:0]      t_near,
   output logic signed [31:0]      t_far
);

   logic signed [31:0] lo_ff [rucs_pkg::AXES];
   logic signed [31:0] hi_ff [rucs_pkg::AXES];
   logic signed [31:0] lo_in [rucs_pkg::AXES];
   logic signed [31:0] hi_in [rucs_pkg::AXES];
   logic signed [31:0] near_ff, far_ff, near_in, far_in;

   // Put each axis span in order.
   always_comb begin
      for (int k = 0; k < rucs_pkg::AXES; k++) begin
         if (t_entry[k] > t_exit[k]) begin
            lo_in[k] = t_exit[k];
            hi_in[k] = t_entry[k];
         end else begin
            lo_in[k] = t_entry[k];
            hi_in[k] = t_exit[k];
         end
      end
   end

   // Largest entry and smallest exit over the axes.
   always_comb begin
      near_in = lo_ff[0];
      far_in  = hi_ff[0];
      for (int k = 1; k < rucs_pkg::AXES; k++) begin
         if (lo_ff[k] > near_in) begin
            near_in = lo_ff[k];
         end
         if (hi_ff[k] < far_in) begin
            far_in = hi_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         near_ff <= near_in;
         far_ff  <= far_in;
      end
   end

   assign t_near = near_ff;
   assign t_far  = far_ff;
   assign hit    = (near_ff <= far_ff);

endmodule
`default_nettype wire

FILE: rtl/core/ray_unit_cube_slab_test.sv
`default_nettype none
// Slab test of a ray against the cube from -1 to 1, one ray per clock
// unless stalled. Six divider lanes, an entry and an exit lane for each
// axis, form the slab parameters in parallel; each lane is a restoring
// divider pipeline that retires one quotient bit per stage, and a
// two-stage merge takes the largest entry and smallest exit. A request
// beat passes 37 register stages on its way to its result beat; the
// pipeline accepts a new beat every cycle and stalls as a whole only
// while a result beat waits on rsp_tready. Times saturate to the Q16.16
// extremes, which stand for infinity.
module ray_unit_cube_slab_test (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
   input  wire logic [191:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // hit, t_near, t_far, zero fill
   output logic [71:0]       rsp_tdata,
   input  wire logic         csr_wr_en,
   input  wire logic [16:0]  csr_wr_data
);

   logic [16:0]                   thresh_ff;
   logic [rucs_pkg::LATENCY-1:0]  vld_ff;
   logic                          en;
   logic signed [31:0]            t_entry [rucs_pkg::AXES];
   logic signed [31:0]            t_exit  [rucs_pkg::AXES];
   logic                          hit;
   logic signed [31:0]            t_near, t_far;

   // The whole pipeline advances unless a result beat is held.
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[rucs_pkg::LATENCY-1];

   // Threshold register and valid pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= rucs_pkg::THRESH_RESET;
         vld_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            thresh_ff <= csr_wr_data;
         end
         if (en) begin
            vld_ff <= {vld_ff[rucs_pkg::LATENCY-2:0], req_tvalid};
         end
      end
   end

   // Entry and exit lanes for each axis.
   for (genvar k = 0; k < rucs_pkg::AXES; k++) begin : g_axis
      rucs_slab_lane u_entry (
         .clock     (clock),
         .en        (en),
         .exit_side (1'b0),
         .thresh    (thresh_ff),
         .origin    (req_tdata[32*k +: 32]),
         .dir       (req_tdata[32*(k+3) +: 32]),
         .t_out     (t_entry[k])
      );
      rucs_slab_lane u_exit (
         .clock     (clock),
         .en        (en),
         .exit_side (1'b1),
         .thresh    (thresh_ff),
         .origin    (req_tdata[32*k +: 32]),
         .dir       (req_tdata[32*(k+3) +: 32]),
         .t_out     (t_exit[k])
      );
   end

   rucs_merge u_merge (
      .clock   (clock),
      .en      (en),
      .t_entry (t_entry),
      .t_exit  (t_exit),
      .hit     (hit),
      .t_near  (t_near),
      .t_far   (t_far)
   );

   assign rsp_tdata = {7'b0, t_far, t_near, hit};

endmodule
`default_nettype wire

FILE: rtl/core/rucs_checker.sv
`default_nettype none
module rucs_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [71:0]  rsp_tdata
);

   // The pipeline is empty right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat valid right after reset");

   // Input stalls exactly when a result beat is held.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("request ready does not follow result backpressure");

   // A held result beat keeps its data.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("held result beat changed");

   // The hit flag agrees with the reported times.
   a_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[0] == ($signed(rsp_tdata[32:1]) <= $signed(rsp_tdata[64:33])))
      else $error("hit flag disagrees with t_near and t_far");

   // The fill bits stay zero.
   a_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[71:65] == 7'b0)
      else $error("fill bits of result beat are not zero");

endmodule

bind ray_unit_cube_slab_test rucs_checker u_rucs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;

   typedef struct packed {
      logic signed [31:0] dz;
      logic signed [31:0] dy;
      logic signed [31:0] dx;
      logic signed [31:0] oz;
      logic signed [31:0] oy;
      logic signed [31:0] ox;
   } ray_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] t_near;
      logic signed [31:0] t_far;
   } span_type;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = rucs_pkg::LATENCY + 10;
   localparam longint Q1 = 65536;
   localparam longint POS_INF = 64'sd2147483647;
   localparam longint NEG_INF = -64'sd2147483648;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [191:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [71:0]  rsp_tdata;
   logic         csr_wr_en = 1'b0;
   logic [16:0]  csr_wr_data = '0;

   ray_type  pending_rays[$];
   span_type expected_spans[$];
   logic [16:0] threshold = rucs_pkg::THRESH_RESET;
   int       error_count = 0;
   int       idle_cycles = 0;
   bit       no_idle = 1'b0;
   bit       pause_send = 1'b0;
   int       hold_count = 0;

   ray_unit_cube_slab_test u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Entry or exit parameter of one slab, saturated to the infinity codes.
   function automatic longint slab_time(longint num, longint d, bit par, bit is_exit);
      longint q;
      if (par) begin
         if (num > 0) return POS_INF;
         if (num < 0) return NEG_INF;
         return is_exit ? POS_INF : NEG_INF;
      end
      q = (num * Q1) / d;
      if (q > POS_INF) return POS_INF;
      if (q < NEG_INF) return NEG_INF;
      return q;
   endfunction

   // Largest entry and smallest exit over the three axes.
   function automatic span_type cube_span(ray_type r);
      longint o[3], d[3];
      longint lo, hi, t, mag, near_t, far_t;
      bit par;
      span_type s;
      o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
      d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
      near_t = NEG_INF;
      far_t = POS_INF;
      for (int k = 0; k < 3; k++) begin
         mag = d[k] < 0 ? -d[k] : d[k];
         par = (d[k] == 0) || (mag < longint'(threshold));
         lo = slab_time(-Q1 - o[k], d[k], par, 1'b0);
         hi = slab_time(Q1 - o[k], d[k], par, 1'b1);
         if (lo > hi) begin
            t = lo; lo = hi; hi = t;
         end
         if (k == 0 || lo > near_t) near_t = lo;
         if (k == 0 || hi < far_t) far_t = hi;
      end
      s.hit = near_t <= far_t;
      s.t_near = near_t[31:0];
      s.t_far = far_t[31:0];
      return s;
   endfunction

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(0, 14) - 7;
         3: return 32'h0001_0000;
         4: return 32'hFFFF_0000;
         5, 6: return $urandom();
         default: return $signed($urandom_range(0, 6 * 65536)) - 3 * 65536;
      endcase
   endfunction

   function automatic ray_type random_ray();
      ray_type r;
      r.ox = pick_coord(); r.oy = pick_coord(); r.oz = pick_coord();
      r.dx = pick_coord(); r.dy = pick_coord(); r.dz = pick_coord();
      return r;
   endfunction

   function automatic ray_type make_ray(logic [31:0] ox, oy, oz, dx, dy, dz);
      ray_type r;
      r.ox = ox; r.oy = oy; r.oz = oz; r.dx = dx; r.dy = dy; r.dz = dz;
      return r;
   endfunction

   // Driver: offers the queued rays, with random gaps.
   always @(negedge clock) begin
      if (!reset) begin
         if (!(req_tvalid && !req_tready)) begin
            if (!pause_send && pending_rays.size() > 0 &&
                (no_idle || $urandom_range(0, 99) >= 27)) begin
               req_tvalid <= 1'b1;
               req_tdata <= pending_rays[0];
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: holds off for a counted stretch when asked, else idles at random.
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_count > 0) begin
            hold_count <= hold_count - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= no_idle || $urandom_range(0, 99) >= 27;
         end
      end
   end

   // Monitor: predicts on each accepted request beat and checks each result beat.
   always @(posedge clock) begin
      span_type want, got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_spans.push_back(cube_span(ray_type'(req_tdata)));
            void'(pending_rays.pop_front());
            req_tvalid <= 1'b0;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.hit = rsp_tdata[0];
            got.t_near = rsp_tdata[32:1];
            got.t_far = rsp_tdata[64:33];
            if (expected_spans.size() == 0) begin
               error_count++;
               if (error_count <= 10) $display("unexpected result beat %h", rsp_tdata);
            end else begin
               want = expected_spans.pop_front();
               if (got !== want) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("mismatch: expected hit %0d near %h far %h",
                              want.hit, want.t_near, want.t_far,
                              ", got hit %0d near %h far %h",
                              got.hit, got.t_near, got.t_far);
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   // Watchdog on cycles with no beat on either side.
   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_rays.size() > 0 || expected_spans.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(logic [16:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      threshold = value;
   endtask

   initial begin
      logic [16:0] settings[5];
      settings[0] = 17'd0;
      settings[1] = 17'd65536;
      settings[2] = 17'd1;
      settings[3] = 17'd300;
      settings[4] = 17'd20000;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rays at the reset threshold: hits, misses, parallel and extreme cases.
      pending_rays.push_back(make_ray(0, 0, 0, 32'h10000, 32'h10000, 32'h10000));
      pending_rays.push_back(make_ray(32'hFFFD0000, 0, 0, 32'h10000, 0, 0));
      pending_rays.push_back(make_ray(32'h30000, 0, 0, 32'h10000, 0, 0));
      pending_rays.push_back(make_ray(0, 32'h30000, 0, 32'h10000, 0, 0));
      pending_rays.push_back(make_ray(32'h10000, 0, 0, 0, 32'h10000, 0));
      pending_rays.push_back(make_ray(32'hFFFF0000, 0, 0, 0, 0, 32'h10000));
      pending_rays.push_back(make_ray(0, 0, 0, 6, 32'hFFFFFFFA, 7));
      pending_rays.push_back(make_ray(0, 0, 0, 1, 1, 1));
      pending_rays.push_back(make_ray(32'h80000000, 32'h7FFFFFFF, 0,
                                      32'h80000000, 32'h7FFFFFFF, 32'h80000000));
      pending_rays.push_back(make_ray(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                                      7, 32'hFFFFFFF9, 8));
      pending_rays.push_back(make_ray(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                                      32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
      pending_rays.push_back(make_ray(0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000));
      wait_drained();

      // Random phases over several thresholds, extremes included.
      for (int p = 0; p < 5; p++) begin
         write_threshold(settings[p]);
         no_idle = (p == 2);
         for (int i = 0; i < 220; i++) pending_rays.push_back(random_ray());
         if (p == 1) begin
            // Long receiver stall while the sender keeps offering rays.
            hold_count = 200;
         end
         if (p == 3) begin
            // Sender pauses halfway until every result has come back.
            while (pending_rays.size() > 110) @(posedge clock);
            pause_send = 1'b1;
            while (req_tvalid || expected_spans.size() > 0) @(posedge clock);
            pause_send = 1'b0;
         end
         wait_drained();
      end

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
`default_nettype wire
